FILE: hdl/stick_direction_repeater_assert.svh
// assertion macros shared by the stick direction repeater
`ifndef STICK_DIRECTION_REPEATER_ASSERT_SVH
`define STICK_DIRECTION_REPEATER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SDR_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SDR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sdr_pkg.sv
package sdr_pkg;

  // field widths
  localparam int unsigned XY_W  = 16;
  localparam int unsigned DT_W  = 16;
  localparam int unsigned THR_W = 15;
  localparam int unsigned SQ_W  = 2 * THR_W;
  localparam int unsigned MAG_W = 32;
  localparam int unsigned TMR_W = 24;
  localparam int unsigned CD_W  = 25;
  localparam int unsigned CFG_W = 24;

  // direction codes
  typedef logic [2:0] dir_t;
  localparam dir_t DIR_NONE  = 3'd0;
  localparam dir_t DIR_UP    = 3'd1;
  localparam dir_t DIR_DOWN  = 3'd2;
  localparam dir_t DIR_LEFT  = 3'd3;
  localparam dir_t DIR_RIGHT = 3'd4;

  // register indexes
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_ENTER   = 2'd0;
  localparam reg_idx_t REG_RELEASE = 2'd1;
  localparam reg_idx_t REG_INITIAL = 2'd2;
  localparam reg_idx_t REG_REPEAT  = 2'd3;

  // reset values, thresholds kept as their squares
  localparam logic [SQ_W-1:0]  ENTER_SQ_RST   = SQ_W'(16384 * 16384);
  localparam logic [SQ_W-1:0]  RELEASE_SQ_RST = SQ_W'(8192 * 8192);
  localparam logic [TMR_W-1:0] INITIAL_RST    = TMR_W'(400000);
  localparam logic [TMR_W-1:0] REPEAT_RST     = TMR_W'(100000);

  // settings handed from the register block to the datapath
  typedef struct packed {
    logic [SQ_W-1:0]  enter_sq;
    logic [SQ_W-1:0]  release_sq;
    logic [TMR_W-1:0] initial_delay;
    logic [TMR_W-1:0] repeat_interval;
  } cfg_t;

endpackage

FILE: hdl/sdr_if.sv
// stick sample channel
interface sdr_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [sdr_pkg::XY_W-1:0]     stick_x;
  logic signed [sdr_pkg::XY_W-1:0]     stick_y;
  logic        [sdr_pkg::DT_W-1:0]     elapsed_time;

  modport source (output valid, stick_x, stick_y, elapsed_time, input ready);
  modport sink   (input valid, stick_x, stick_y, elapsed_time, output ready);
endinterface

// direction event channel
interface sdr_event_if;
  logic          valid;
  logic          ready;
  sdr_pkg::dir_t direction_event;

  modport source (output valid, direction_event, input ready);
  modport sink   (input valid, direction_event, output ready);
endinterface

FILE: hdl/sdr_cfg.sv
module sdr_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  sdr_pkg::reg_idx_t wr_index,
  input  logic [sdr_pkg::CFG_W-1:0] wr_data,
  output sdr_pkg::cfg_t     cfg
);

  logic [sdr_pkg::THR_W-1:0] thr;
  logic [sdr_pkg::SQ_W-1:0]  thr_sq;

  // thresholds are squared once on write
  assign thr    = wr_data[sdr_pkg::THR_W-1:0];
  assign thr_sq = sdr_pkg::SQ_W'(thr * thr);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enter_sq        <= sdr_pkg::ENTER_SQ_RST;
      cfg.release_sq      <= sdr_pkg::RELEASE_SQ_RST;
      cfg.initial_delay   <= sdr_pkg::INITIAL_RST;
      cfg.repeat_interval <= sdr_pkg::REPEAT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        sdr_pkg::REG_ENTER:   cfg.enter_sq        <= thr_sq;
        sdr_pkg::REG_RELEASE: cfg.release_sq      <= thr_sq;
        sdr_pkg::REG_INITIAL: cfg.initial_delay   <= wr_data[sdr_pkg::TMR_W-1:0];
        sdr_pkg::REG_REPEAT:  cfg.repeat_interval <= wr_data[sdr_pkg::TMR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/stick_direction_repeater.sv
// a sample passes the input stage, magnitude stage and result register to the output
// throughput: one sample per cycle while events.ready is high; a low events.ready
// stalls the single squaring stage and the state update stage back to samples.ready
// reset: synchronous, clears held direction and countdown, restores register defaults
module stick_direction_repeater (
  input  logic                      clk,
  input  logic                      rst,
  sdr_sample_if.sink                samples,
  sdr_event_if.source               events,
  input  logic                      wr_en,
  input  sdr_pkg::reg_idx_t         wr_index,
  input  logic [sdr_pkg::CFG_W-1:0] wr_data
);

`include "stick_direction_repeater_assert.svh"

  sdr_pkg::cfg_t cfg;

  // input stage
  logic                              s1_valid;
  logic signed [sdr_pkg::XY_W-1:0]   s1_x;
  logic signed [sdr_pkg::XY_W-1:0]   s1_y;
  logic        [sdr_pkg::DT_W-1:0]   s1_dt;

  // magnitude stage
  logic                              s2_valid;
  logic        [sdr_pkg::MAG_W-1:0]  s2_mag;
  sdr_pkg::dir_t                     s2_dir;
  logic        [sdr_pkg::DT_W-1:0]   s2_dt;

  // result register and state
  logic                              o_valid;
  sdr_pkg::dir_t                     o_event;
  sdr_pkg::dir_t                     held_direction;
  sdr_pkg::dir_t                     held_direction_next;
  logic        [sdr_pkg::CD_W-1:0]   repeat_countdown;
  logic        [sdr_pkg::CD_W-1:0]   repeat_countdown_next;
  sdr_pkg::dir_t                     event_next;

  logic                              o_load;
  logic                              s2_en;
  logic                              s1_en;

  logic signed [sdr_pkg::MAG_W-1:0]  sq_x;
  logic signed [sdr_pkg::MAG_W-1:0]  sq_y;
  logic        [sdr_pkg::MAG_W-1:0]  mag;
  logic        [sdr_pkg::XY_W-1:0]   ax;
  logic        [sdr_pkg::XY_W-1:0]   ay;
  sdr_pkg::dir_t                     dir;

  logic                              below_enter;
  logic                              below_release;
  logic        [sdr_pkg::CD_W:0]     left;
  logic                              left_pos;

  sdr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // pipeline flow control
  assign o_load        = s2_valid && (!o_valid || events.ready);
  assign s2_en         = !s2_valid || o_load;
  assign s1_en         = !s1_valid || s2_en;
  assign samples.ready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_x  <= samples.stick_x;
      s1_y  <= samples.stick_y;
      s1_dt <= samples.elapsed_time;
    end
  end

  // squared magnitude and dominant axis
  assign sq_x = s1_x * s1_x;
  assign sq_y = s1_y * s1_y;
  assign mag  = {1'b0, sq_x[sdr_pkg::MAG_W-2:0]} + {1'b0, sq_y[sdr_pkg::MAG_W-2:0]};
  assign ax   = s1_x[sdr_pkg::XY_W-1] ? sdr_pkg::XY_W'(-s1_x) : s1_x;
  assign ay   = s1_y[sdr_pkg::XY_W-1] ? sdr_pkg::XY_W'(-s1_y) : s1_y;

  // vertical axis wins a tie, zero vector counts as down
  always_comb begin
    if (ax > ay) begin
      dir = s1_x[sdr_pkg::XY_W-1] ? sdr_pkg::DIR_LEFT : sdr_pkg::DIR_RIGHT;
    end else begin
      dir = s1_y[sdr_pkg::XY_W-1] ? sdr_pkg::DIR_UP : sdr_pkg::DIR_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_mag <= mag;
      s2_dir <= dir;
      s2_dt  <= s1_dt;
    end
  end

  // hysteresis compares and countdown
  assign below_enter   = s2_mag < {2'b0, cfg.enter_sq};
  assign below_release = s2_mag < {2'b0, cfg.release_sq};
  assign left          = {1'b0, repeat_countdown} - {10'b0, s2_dt};
  assign left_pos      = !left[sdr_pkg::CD_W] && (left != '0);

  // press, release and repeat decisions
  always_comb begin
    held_direction_next   = held_direction;
    repeat_countdown_next = repeat_countdown;
    event_next            = sdr_pkg::DIR_NONE;
    priority if (held_direction == sdr_pkg::DIR_NONE && below_enter) begin
      held_direction_next = sdr_pkg::DIR_NONE;
    end else if (held_direction != sdr_pkg::DIR_NONE && below_release) begin
      held_direction_next   = sdr_pkg::DIR_NONE;
      repeat_countdown_next = '0;
    end else if (s2_dir != held_direction) begin
      held_direction_next   = s2_dir;
      repeat_countdown_next = {1'b0, cfg.initial_delay};
      event_next            = s2_dir;
    end else if (left_pos) begin
      repeat_countdown_next = left[sdr_pkg::CD_W-1:0];
    end else begin
      repeat_countdown_next = {1'b0, cfg.repeat_interval};
      event_next            = held_direction;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_direction   <= sdr_pkg::DIR_NONE;
      repeat_countdown <= '0;
      o_valid          <= 1'b0;
    end else begin
      if (o_load) begin
        held_direction   <= held_direction_next;
        repeat_countdown <= repeat_countdown_next;
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (events.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_event <= event_next;
    end
  end

  assign events.valid           = o_valid;
  assign events.direction_event = o_event;

  // checks
  `SDR_ASSERT_SAME(a_idle_countdown_clear, clk, rst,
    held_direction == sdr_pkg::DIR_NONE, repeat_countdown == '0,
    "countdown not clear while nothing is held")
  `SDR_ASSERT_NEXT(a_event_matches_held, clk, rst,
    o_load && event_next != sdr_pkg::DIR_NONE,
    held_direction == events.direction_event,
    "reported direction differs from held direction")
  `SDR_ASSERT_NEXT(a_state_only_on_transaction, clk, rst,
    !o_load, held_direction == $past(held_direction),
    "held direction changed without a transaction")
  `SDR_ASSERT_NEXT(a_stage_holds_when_stalled, clk, rst,
    s2_valid && !o_load, s2_valid && $stable(s2_mag) && $stable(s2_dir),
    "stalled sample lost in magnitude stage")

endmodule
